@@ rtl/caf_pkg.sv @@
// Package for the contrast autofocus hill-climb block: field widths, reset values,
// configuration register indexes and the divide-by-twenty helper.
// No dependencies.
`default_nettype none

package caf_pkg;

    // Field widths fixed by the interface
    localparam int POS_W     = 10;
    localparam int STEP_W    = 8;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W      = 32;

    // Defaults for the top-level parameters
    localparam int DEFAULT_MAX_POSITION  = 1023;
    localparam int DEFAULT_CONTRAST_BITS = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_STEP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_STEP   = 2'd3;

    // Register reset values
    localparam logic [POS_W-1:0]  LOW_STEP_RST    = 10'd0;
    localparam logic [POS_W-1:0]  HIGH_STEP_RST   = 10'd1023;
    localparam logic [STEP_W-1:0] COARSE_STEP_RST = 8'd30;
    localparam logic [STEP_W-1:0] FINE_STEP_RST   = 8'd1;

    // Reciprocal of twenty scaled by 2^16; the quotient is exact below 16384.
    localparam logic [11:0] DIV20_MUL = 12'd3277;

    // Floor of x / 20 for an 11-bit value, by reciprocal multiplication.
    function automatic logic [6:0] div20(input logic [10:0] x);
        logic [22:0] prod;
        prod = 23'(x) * 23'(DIV20_MUL);
        return prod[22:16];
    endfunction

endpackage

`default_nettype wire

@@ rtl/contrast_autofocus_hill_climb.sv @@
// Contrast-detect autofocus by coarse then fine hill climbing, one frame per item.
// An accepted item is held in the input register, then its result is registered in the
// state/result registers and offered at the output. Throughput: one item per cycle while
// the output is not stalled.
// Reset (rst_n low, asynchronous) loads the register defaults, clears the scan state
// and sets the scan limit to the top position.
`default_nettype none

module contrast_autofocus_hill_climb
    import caf_pkg::*;
#(
    parameter int MAX_POSITION  = DEFAULT_MAX_POSITION,
    parameter int CONTRAST_BITS = DEFAULT_CONTRAST_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write port
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // Input channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [IN_W-1:0]      frame_contrast,
    // Output channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [POS_W-1:0]          lens_position,
    output logic                      in_focus
);

    localparam int CW      = CONTRAST_BITS;
    localparam int CAP_INT = (MAX_POSITION > 1023) ? 1023 : MAX_POSITION;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(CAP_INT);

    // Configuration registers
    logic [POS_W-1:0]  low_step_reg, low_step_next;
    logic [POS_W-1:0]  high_step_reg, high_step_next;
    logic [STEP_W-1:0] coarse_step_reg, coarse_step_next;
    logic [STEP_W-1:0] fine_step_reg, fine_step_next;

    // Input register
    logic              in_vld_reg, in_vld_next;
    logic [IN_W-1:0]   contrast_reg;

    // Scan state; lens_pos_reg and focused_reg double as the result register
    logic [POS_W-1:0]  focus_pos_reg, focus_pos_next;
    logic [POS_W-1:0]  best_pos_reg, best_pos_next;
    logic [POS_W-1:0]  scan_limit_reg, scan_limit_next;
    logic [POS_W-1:0]  lens_pos_reg, lens_pos_next;
    logic [POS_W-1:0]  fine_start_reg, fine_start_next;
    logic [CW-1:0]     peak_reg, peak_next;
    logic              coarse_done_reg, coarse_done_next;
    logic              focused_reg, focused_next;
    logic              out_vld_reg, out_vld_next;

    // Datapath signals
    logic              advance;
    logic              in_load;
    logic [CW-1:0]     c;
    logic [CW+3:0]     ten_c;
    logic [CW+3:0]     nine_p;
    logic              ge;
    logic [POS_W:0]    coarse_sum;
    logic              coarse_over;
    logic              coarse_active;
    logic              coarse_end;
    logic [POS_W:0]    fine_top;
    logic [POS_W-1:0]  high_cap;
    logic [POS_W-1:0]  low_cap;
    logic [POS_W-1:0]  top_lim;
    logic [POS_W-1:0]  f_focus;
    logic [POS_W-1:0]  f_limit;
    logic [POS_W:0]    fine_sum;
    logic              fine_over;
    logic              fine_ok;
    logic [CW-1:0]     diff;
    logic              out_of_focus;
    logic [POS_W-1:0]  cfg_low;
    logic [POS_W-1:0]  cfg_high;

    // Handshake: the state advances when an item is held and the result register is free or being taken.
    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign in_load   = in_valid && !in_stall;
    assign out_valid = out_vld_reg;

    assign lens_position = lens_pos_reg;
    assign in_focus      = focused_reg;

    always_comb
    begin
        in_vld_next  = in_load ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        out_vld_next = advance || (out_vld_reg && out_stall);
    end

    // Contrast comparison against nine tenths of the peak, and focus-loss test.
    assign c      = CW'(contrast_reg);
    assign ten_c  = (CW+4)'({c, 3'b000}) + (CW+4)'({c, 1'b0});
    assign nine_p = (CW+4)'({peak_reg, 3'b000}) + (CW+4)'(peak_reg);
    assign ge     = ten_c >= nine_p;

    assign diff         = (c >= peak_reg) ? (c - peak_reg) : (peak_reg - c);
    assign out_of_focus = {diff, 1'b0} > {1'b0, peak_reg};

    // Position limits clamped to the actuator range
    assign high_cap = (high_step_reg > POS_CAP) ? POS_CAP : high_step_reg;
    assign low_cap  = (low_step_reg > POS_CAP) ? POS_CAP : low_step_reg;

    // Coarse step test
    assign coarse_active = !focused_reg && !coarse_done_reg;
    assign coarse_sum    = {1'b0, focus_pos_reg} + (POS_W+1)'(coarse_step_reg);
    assign coarse_over   = coarse_sum > {1'b0, scan_limit_reg};
    assign coarse_end    = coarse_active && (coarse_over || !ge);

    // Fine window: the start is kept precomputed from the best position.
    assign fine_top = {1'b0, fine_start_reg}
                    + (POS_W+1)'(div20({1'b0, fine_start_reg}));
    assign top_lim  = (fine_top > {1'b0, high_cap}) ? high_cap : fine_top[POS_W-1:0];

    // Fine step test, either continuing a fine scan or starting one this frame
    assign f_focus   = coarse_end ? fine_start_reg : focus_pos_reg;
    assign f_limit   = coarse_end ? top_lim : scan_limit_reg;
    assign fine_sum  = {1'b0, f_focus} + (POS_W+1)'(fine_step_reg);
    assign fine_over = fine_sum > {1'b0, f_limit};
    assign fine_ok   = !fine_over && (coarse_end || ge);

    // Next scan state and configuration
    always_comb
    begin
        low_step_next    = low_step_reg;
        high_step_next   = high_step_reg;
        coarse_step_next = coarse_step_reg;
        fine_step_next   = fine_step_reg;
        focus_pos_next   = focus_pos_reg;
        best_pos_next    = best_pos_reg;
        scan_limit_next  = scan_limit_reg;
        lens_pos_next    = lens_pos_reg;
        peak_next        = peak_reg;
        coarse_done_next = coarse_done_reg;
        focused_next     = focused_reg;
        cfg_low          = cfg_data[POS_W-1:0];
        cfg_high         = cfg_data[POS_W-1:0];

        if (advance)
        begin
            if (!focused_reg)
            begin
                if (coarse_active && !coarse_end)
                begin
                    // Coarse step kept
                    best_pos_next  = focus_pos_reg;
                    focus_pos_next = coarse_sum[POS_W-1:0];
                    lens_pos_next  = coarse_sum[POS_W-1:0];
                    peak_next      = c;
                end
                else
                begin
                    // Fine scan, entered from the coarse scan this frame or already running
                    coarse_done_next = 1'b1;
                    scan_limit_next  = f_limit;
                    if (fine_ok)
                    begin
                        best_pos_next  = f_focus;
                        focus_pos_next = fine_sum[POS_W-1:0];
                        lens_pos_next  = fine_sum[POS_W-1:0];
                        peak_next      = c;
                    end
                    else
                    begin
                        focus_pos_next = f_focus;
                        lens_pos_next  = best_pos_reg;
                        peak_next      = coarse_end ? '0 : peak_reg;
                        focused_next   = 1'b1;
                    end
                end
            end
            else if (out_of_focus)
            begin
                // Focus lost: restart the whole scan from the low end
                lens_pos_next    = low_cap;
                focus_pos_next   = low_cap;
                scan_limit_next  = high_cap;
                focused_next     = 1'b0;
                coarse_done_next = 1'b0;
                peak_next        = '0;
            end
        end

        if (cfg_write)
        begin
            case (cfg_index)
                REG_LOW_STEP:
                begin
                    low_step_next   = cfg_low;
                    focus_pos_next  = (cfg_low > POS_CAP) ? POS_CAP : cfg_low;
                    scan_limit_next = high_cap;
                end
                REG_HIGH_STEP:
                begin
                    high_step_next  = cfg_high;
                    focus_pos_next  = low_cap;
                    scan_limit_next = (cfg_high > POS_CAP) ? POS_CAP : cfg_high;
                end
                REG_COARSE_STEP:
                begin
                    coarse_step_next = cfg_data[STEP_W-1:0];
                end
                REG_FINE_STEP:
                begin
                    fine_step_next = cfg_data[STEP_W-1:0];
                end
                default:
                begin
                    low_step_next = low_step_reg;
                end
            endcase
        end

        // Fine scan start is 95% of the best position: best - ceil(best / 20).
        fine_start_next = best_pos_next
                        - POS_W'(div20({1'b0, best_pos_next} + (POS_W+1)'(19)));
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_step_reg    <= LOW_STEP_RST;
            high_step_reg   <= HIGH_STEP_RST;
            coarse_step_reg <= COARSE_STEP_RST;
            fine_step_reg   <= FINE_STEP_RST;
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            focus_pos_reg   <= '0;
            best_pos_reg    <= '0;
            scan_limit_reg  <= POS_CAP;
            lens_pos_reg    <= '0;
            fine_start_reg  <= '0;
            peak_reg        <= '0;
            coarse_done_reg <= 1'b0;
            focused_reg     <= 1'b0;
        end
        else
        begin
            low_step_reg    <= low_step_next;
            high_step_reg   <= high_step_next;
            coarse_step_reg <= coarse_step_next;
            fine_step_reg   <= fine_step_next;
            in_vld_reg      <= in_vld_next;
            out_vld_reg     <= out_vld_next;
            focus_pos_reg   <= focus_pos_next;
            best_pos_reg    <= best_pos_next;
            scan_limit_reg  <= scan_limit_next;
            lens_pos_reg    <= lens_pos_next;
            fine_start_reg  <= fine_start_next;
            peak_reg        <= peak_next;
            coarse_done_reg <= coarse_done_next;
            focused_reg     <= focused_next;
        end
    end

    // Input item payload
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            contrast_reg <= frame_contrast;
        end
    end

`ifndef SYNTH
    // Focus can only be held once the coarse scan has finished.
    a_focus_after_coarse: assert property (@(posedge clk) disable iff (!rst_n)
        focused_reg |-> coarse_done_reg)
        else $error("focus held without a finished coarse scan");

    // Every processed item yields a result on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("processed item produced no result");

    // On reaching focus the lens returns to the best position.
    a_focus_at_best: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !focused_reg && focused_next) |=> (lens_pos_reg == best_pos_reg))
        else $error("lens not at best position when focus reached");

    // The fine scan start never lies above the best position.
    a_start_below_best: assert property (@(posedge clk) disable iff (!rst_n)
        fine_start_reg <= best_pos_reg)
        else $error("fine scan start above best position");
`endif

endmodule

`default_nettype wire

@@ sim/hill_climb_checker.sv @@
// Checker for the contrast autofocus hill-climb block: watches the register port and both
// item channels, predicts each result and compares it field by field.
// Depends on caf_pkg for widths and register indexes.
module hill_climb_checker
    import caf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [IN_W-1:0]      frame_contrast,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [POS_W-1:0]     lens_position,
    input  logic                 in_focus,
    output int                   mismatches,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             focused;
    } lens_cmd_t;

    // Lens commands still owed by the block, oldest first.
    lens_cmd_t lens_cmd_q[$];

    // Shadow of the configuration registers.
    logic [POS_W-1:0]  low_pos;
    logic [POS_W-1:0]  high_pos;
    logic [STEP_W-1:0] coarse_inc;
    logic [STEP_W-1:0] fine_inc;

    // Shadow of the scan state.
    logic [POS_W-1:0]  probe_pos;
    logic [POS_W-1:0]  best_pos;
    logic [POS_W-1:0]  limit_pos;
    logic [POS_W-1:0]  lens_pos;
    logic [IN_W-1:0]   peak_level;
    logic              coarse_over;
    logic              locked;
    int                error_count;

    // One hill-climb step. Positions are 10 bits, so clamping to the top position never
    // changes a value here. Returns 1 when the current pass has ended.
    function automatic logic climb(input logic [IN_W-1:0] level, input logic [STEP_W-1:0] inc);
        logic [POS_W:0] next_pos;
        next_pos = (POS_W+1)'(probe_pos) + (POS_W+1)'(inc);
        if (next_pos > (POS_W+1)'(limit_pos))
        begin
            lens_pos = best_pos;
            return 1'b1;
        end
        // Keep climbing while contrast holds at nine tenths of the peak or better.
        if ((IN_W+4)'(level) * 10 >= (IN_W+4)'(peak_level) * 9)
        begin
            best_pos   = probe_pos;
            probe_pos  = next_pos[POS_W-1:0];
            peak_level = level;
            lens_pos   = probe_pos;
            return 1'b0;
        end
        lens_pos = best_pos;
        return 1'b1;
    endfunction

    // Advances the shadow state by one frame and returns the lens command it produces.
    function automatic lens_cmd_t next_lens_cmd(input logic [IN_W-1:0] level);
        logic [POS_W+6:0] scaled;
        logic [POS_W:0]   start_pos;
        logic [POS_W:0]   top_pos;
        logic [IN_W:0]    gap;
        lens_cmd_t        cmd;
        if (!locked)
        begin
            if (!coarse_over)
            begin
                // Coarse pass over: fine pass starts at 95% of the chosen position.
                if (climb(level, coarse_inc))
                begin
                    coarse_over = 1'b1;
                    peak_level  = '0;
                    scaled      = (POS_W+7)'(lens_pos) * (POS_W+7)'(95)
                                / (POS_W+7)'(100);
                    start_pos   = scaled[POS_W:0];
                    top_pos     = start_pos + start_pos / (POS_W+1)'(20);
                    probe_pos   = start_pos[POS_W-1:0];
                    lens_pos    = start_pos[POS_W-1:0];
                    limit_pos   = (top_pos > (POS_W+1)'(high_pos)) ? high_pos
                                                                    : top_pos[POS_W-1:0];
                end
            end
            if (coarse_over)
            begin
                if (climb(level, fine_inc))
                    locked = 1'b1;
            end
        end
        else
        begin
            // Holding focus: a change of more than half the peak restarts the scan.
            gap = (level >= peak_level) ? (IN_W+1)'(level - peak_level)
                                        : (IN_W+1)'(peak_level - level);
            if ((IN_W+2)'(gap) * 2 > (IN_W+2)'(peak_level))
            begin
                lens_pos    = low_pos;
                probe_pos   = low_pos;
                limit_pos   = high_pos;
                locked      = 1'b0;
                coarse_over = 1'b0;
                peak_level  = '0;
            end
        end
        cmd.position = lens_pos;
        cmd.focused  = locked;
        return cmd;
    endfunction

    // Observe the port at each edge: results first, then register writes, then new items.
    always @(posedge clk or negedge rst_n)
    begin
        lens_cmd_t want;
        if (!rst_n)
        begin
            low_pos     = LOW_STEP_RST;
            high_pos    = HIGH_STEP_RST;
            coarse_inc  = COARSE_STEP_RST;
            fine_inc    = FINE_STEP_RST;
            probe_pos   = '0;
            best_pos    = '0;
            limit_pos   = HIGH_STEP_RST;
            lens_pos    = '0;
            peak_level  = '0;
            coarse_over = 1'b0;
            locked      = 1'b0;
            error_count = 0;
            lens_cmd_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (lens_cmd_q.size() == 0)
                begin
                    $display("%0t ns: unexpected item, lens_position %0d in_focus %0b",
                             $time, lens_position, in_focus);
                    error_count++;
                end
                else
                begin
                    want = lens_cmd_q.pop_front();
                    if (lens_position !== want.position)
                    begin
                        $display("%0t ns: lens_position expected %0d, got %0d",
                                 $time, want.position, lens_position);
                        error_count++;
                    end
                    if (in_focus !== want.focused)
                    begin
                        $display("%0t ns: in_focus expected %0b, got %0b",
                                 $time, want.focused, in_focus);
                        error_count++;
                    end
                end
            end

            // A range write also reloads the scan position and the limit.
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_LOW_STEP:
                    begin
                        low_pos   = cfg_data[POS_W-1:0];
                        probe_pos = low_pos;
                        limit_pos = high_pos;
                    end
                    REG_HIGH_STEP:
                    begin
                        high_pos  = cfg_data[POS_W-1:0];
                        probe_pos = low_pos;
                        limit_pos = high_pos;
                    end
                    REG_COARSE_STEP: coarse_inc = cfg_data[STEP_W-1:0];
                    REG_FINE_STEP:   fine_inc   = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                lens_cmd_q.push_back(next_lens_cmd(frame_contrast));

            mismatches  <= error_count;
            outstanding <= lens_cmd_q.size();
        end
    end

endmodule

@@ sim/tb_contrast_autofocus_hill_climb.sv @@
// Testbench top for the contrast autofocus hill-climb block: clock, reset, register
// writes, frame stimulus with random idling, a watchdog and the verdict.
// Depends on caf_pkg, the block itself and hill_climb_checker.
module tb_contrast_autofocus_hill_climb;
    import caf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 100;
    localparam int PHASE_ITEMS = 460;
    localparam int SEGMENTS    = 5;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_LOW_STEP;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [IN_W-1:0]      frame_contrast = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [POS_W-1:0]     lens_position;
    logic                 in_focus;

    int mismatches;
    int outstanding;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int frames_sent = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int quiet_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    contrast_autofocus_hill_climb dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .frame_contrast (frame_contrast),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .lens_position  (lens_position),
        .in_focus       (in_focus)
    );

    hill_climb_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .frame_contrast (frame_contrast),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .lens_position  (lens_position),
        .in_focus       (in_focus),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_done < holds_asked)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Watchdog: ends the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one frame, after optional idle cycles, and returns once it is taken.
    // Valid stays high afterwards so that back-to-back items need no gap.
    task automatic send_frame(input logic [IN_W-1:0] level);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        frame_contrast <= level;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        frames_sent++;
    endtask

    // Stops offering and waits until every owed result has arrived, plus a short tail.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Random scan range and steps, with the extremes picked often.
    task automatic program_random_lens();
        int low_v;
        int high_v;
        int coarse_v;
        int fine_v;
        case ($urandom_range(0, 3))
            0:       low_v = 0;
            1:       low_v = 1023;
            default: low_v = $urandom_range(0, 500);
        endcase
        case ($urandom_range(0, 4))
            0:       high_v = 1023;
            1:       high_v = low_v + $urandom_range(0, 60);
            2:       high_v = $urandom_range(0, 1023);
            default: high_v = low_v + $urandom_range(100, 500);
        endcase
        if (high_v > 1023)
            high_v = 1023;
        case ($urandom_range(0, 3))
            0:       coarse_v = $urandom_range(0, 1023);
            1:       coarse_v = 1;
            default: coarse_v = $urandom_range(1, 64);
        endcase
        case ($urandom_range(0, 3))
            0:       fine_v = $urandom_range(0, 1023);
            default: fine_v = $urandom_range(1, 6);
        endcase
        write_reg(REG_LOW_STEP, CFG_W'(low_v));
        write_reg(REG_HIGH_STEP, CFG_W'(high_v));
        write_reg(REG_COARSE_STEP, CFG_W'(coarse_v));
        write_reg(REG_FINE_STEP, CFG_W'(fine_v));
    endtask

    // Next frame of a rising contrast curve, saturating at full scale.
    function automatic logic [IN_W-1:0] brighter(input logic [IN_W-1:0] level);
        logic [IN_W:0] sum;
        sum = (IN_W+1)'(level) + (IN_W+1)'(level >> 4) + (IN_W+1)'($urandom_range(0, 255));
        return sum[IN_W] ? '1 : sum[IN_W-1:0];
    endfunction

    // Focus sweeps: coarse rise and fall, fine rise and fall, a steady hold, then an
    // upset that should restart the scan. Some frames are plain noise.
    task automatic run_scenes(input int count);
        int goal;
        int k;
        logic [IN_W-1:0] level;
        goal = frames_sent + count;
        while (frames_sent < goal)
        begin
            if ($urandom_range(0, 9) == 0)
                send_frame($urandom());
            else
            begin
                level = $urandom() >> $urandom_range(0, 31);
                k = $urandom_range(1, 40);
                repeat (k)
                begin
                    send_frame(level);
                    level = brighter(level);
                end
                send_frame(level >> $urandom_range(1, 8));
                k = $urandom_range(0, 12);
                repeat (k)
                begin
                    send_frame(level);
                    level = brighter(level);
                end
                send_frame(level >> $urandom_range(1, 8));
                k = $urandom_range(1, 10);
                repeat (k)
                    send_frame(level - ($urandom() % ((level >> 2) + 1)));
                if ($urandom_range(0, 1) == 1)
                    send_frame(level >> $urandom_range(2, 31));
                else
                    send_frame(~level);
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default registers: full-scale, zero and equal contrast.
        send_frame('0);
        send_frame('1);
        send_frame('1);
        send_frame(32'h8000_0000);
        send_frame(32'h0000_0001);
        send_frame('0);
        send_frame(32'h7FFF_FFFF);
        send_frame(32'h7FFF_FFFF);
        settle();

        // Empty range: focus is held with a zero peak, then any nonzero frame restarts.
        write_reg(REG_LOW_STEP, '0);
        write_reg(REG_HIGH_STEP, '0);
        send_frame('0);
        send_frame('0);
        send_frame(32'h0000_0001);
        send_frame('0);
        settle();

        // Low above high, and both steps zero.
        write_reg(REG_LOW_STEP, 10'd1023);
        write_reg(REG_HIGH_STEP, 10'd100);
        write_reg(REG_COARSE_STEP, '0);
        write_reg(REG_FINE_STEP, '0);
        send_frame(32'd5);
        send_frame(32'd5);
        send_frame(32'd100);
        send_frame(32'd1);
        settle();

        // Zero steps inside a valid range: the scan ends only on a contrast drop.
        write_reg(REG_LOW_STEP, 10'd10);
        write_reg(REG_HIGH_STEP, 10'd50);
        send_frame(32'd9);
        send_frame(32'd9);
        send_frame(32'd9);
        send_frame(32'd2);
        send_frame(32'd2);
        settle();

        // Step writes with the upper data bits set keep only the low byte.
        write_reg(REG_COARSE_STEP, '1);
        write_reg(REG_FINE_STEP, '1);
        send_frame(32'd3);
        send_frame(32'd4);
        send_frame('0);

        // Random part: receiver slow then sender slow, then neither idles.
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 75 : 0;
            rx_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 13 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                settle();
                program_random_lens();
                if (seg == 2)
                    holds_asked++;
                run_scenes(PHASE_ITEMS / SEGMENTS);
            end
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ contrast_autofocus_hill_climb.f @@
rtl/caf_pkg.sv
rtl/contrast_autofocus_hill_climb.sv
sim/hill_climb_checker.sv
sim/tb_contrast_autofocus_hill_climb.sv
